FILE: hdl/cbe_pkg.sv
// Shared types and constants for the credential base64 encoder.
// Holds the request and result payload structs, the command codes and the alphabet map.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cbe_pkg;

  // Width of the character counter and required-length field
  localparam int LEN_BITS = 13;
  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  // Command codes
  localparam logic [1:0] CMD_USER = 2'd0;
  localparam logic [1:0] CMD_PASS = 2'd1;
  localparam logic [1:0] CMD_END  = 2'd2;

  // Special characters
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_PAD   = 8'h3D;

  // Group count that means "no bytes": an empty end marker
  localparam logic [1:0] GRP_EMPTY = 2'd0;
  localparam logic [1:0] GRP_FULL  = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } cbe_in_t;

  typedef struct packed {
    logic [7:0]          out_char;
    logic                char_present;
    logic                char_kept;
    logic                last_result;
    logic [LEN_BITS-1:0] required_length;
  } cbe_out_t;

  // One finished group handed from the gatherer to the character emitter
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] nbytes;
    logic       is_end;
  } cbe_job_t;

  // Map a 6-bit value to its base64 alphabet character
  function automatic logic [7:0] cbe_sym(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] c;
    w = {2'b00, v};
    if (v < 6'd26) begin
      c = w + 8'd65;
    end else if (v < 6'd52) begin
      c = w + 8'd71;
    end else if (v < 6'd62) begin
      c = w - 8'd4;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

FILE: hdl/credential_base64_encoder.sv
// Top level of the credential base64 encoder: configuration register,
// byte gatherer and character emitter. Depends on cbe_pkg, cbe_ingest, cbe_emit.
//
// Usage:
//  - Input requests carry a command (user byte, password byte, end) and a byte;
//    a request is taken when in_valid and in_ready are both high.
//  - Results carry one base64 character each (or an empty end marker) and are
//    taken when out_valid and out_ready are both high. The end request's last
//    result has last_result set and reports required_length.
//  - Register output_limit sits at byte address 0 of the cfg_ port; write it
//    only while the block is idle.
//  - out_valid rises once the request that completes a group has passed the
//    job register and then the result register; the group then streams at
//    one character a cycle while out_ready stays high. A request that only
//    buffers its byte leaves in_ready high; one that releases a group holds
//    in_ready low until the emitter has taken the group's last character.
//  - When the receiver stalls, the result and the group being emitted hold and
//    in_ready stays low until that group's last character is registered.
//  - Reset empties all state and sets output_limit to all ones.
`timescale 1ns / 1ps

module credential_base64_encoder import cbe_pkg::*; #(
  parameter int LIMIT_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  cbe_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output cbe_out_t    out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic REG_OUTPUT_LIMIT = 1'b0;

  logic [LIMIT_BITS-1:0] limit_r;
  logic                  cfg_wr;
  logic                  job_valid, job_pop;
  cbe_job_t              job;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == REG_OUTPUT_LIMIT);

  // Hold the output limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '1;
    end else if (cfg_wr) begin
      limit_r <= cfg_pwdata[LIMIT_BITS-1:0];
    end
  end

  // Return the register on read
  assign cfg_prdata = (cfg_paddr[2] == REG_OUTPUT_LIMIT) ? 32'(limit_r) : 32'd0;

  cbe_ingest u_ingest (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  cbe_emit #(
    .LIMIT_BITS (LIMIT_BITS)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .limit     (limit_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: hdl/cbe_ingest.sv
// Byte gatherer: inserts the colon, collects bytes into groups of three and
// hands complete or flushed groups to the emitter. Depends on cbe_pkg.
`timescale 1ns / 1ps

module cbe_ingest import cbe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  cbe_in_t  in_data,
  output logic     job_valid,
  output cbe_job_t job,
  input  logic     job_pop
);

  logic [15:0] pend_r, pend_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        colon_r, colon_nxt;
  logic        job_valid_r;
  cbe_job_t    job_r, job_nxt;
  logic        produce;
  logic        accept;

  // Intermediate state after the optional colon
  logic [15:0] pend_a;
  logic [1:0]  cnt_a;
  logic        add_colon;
  logic        grp_a_vld, grp_b_vld;
  cbe_job_t    grp_a, grp_b;

  assign accept   = in_valid && in_ready;
  assign in_ready = !job_valid_r || job_pop;

  // Insert the colon ahead of the first password byte or the end request
  always_comb begin
    add_colon = !colon_r && (in_data.command == CMD_PASS || in_data.command == CMD_END);
    pend_a    = pend_r;
    cnt_a     = cnt_r;
    grp_a_vld = 1'b0;
    grp_a     = '{b0: pend_r[15:8], b1: pend_r[7:0], b2: CHAR_COLON,
                  nbytes: GRP_FULL, is_end: 1'b0};
    if (add_colon) begin
      if (cnt_r == 2'd2) begin
        grp_a_vld = 1'b1;
        pend_a    = '0;
        cnt_a     = '0;
      end else begin
        pend_a = {pend_r[7:0], CHAR_COLON};
        cnt_a  = cnt_r + 2'd1;
      end
    end
  end

  // Push the data byte or flush the partial group
  always_comb begin
    pend_nxt  = pend_r;
    cnt_nxt   = cnt_r;
    colon_nxt = colon_r;
    grp_b_vld = 1'b0;
    grp_b     = '{b0: pend_a[15:8], b1: pend_a[7:0], b2: in_data.data_byte,
                  nbytes: GRP_FULL, is_end: 1'b0};
    unique case (in_data.command)
      CMD_USER, CMD_PASS: begin
        colon_nxt = colon_r || (in_data.command == CMD_PASS);
        if (cnt_a == 2'd2) begin
          grp_b_vld = 1'b1;
          pend_nxt  = '0;
          cnt_nxt   = '0;
        end else begin
          pend_nxt = {pend_a[7:0], in_data.data_byte};
          cnt_nxt  = cnt_a + 2'd1;
        end
      end
      CMD_END: begin
        pend_nxt  = '0;
        cnt_nxt   = '0;
        colon_nxt = 1'b0;
        if (cnt_a == 2'd1) begin
          grp_b_vld = 1'b1;
          grp_b = '{b0: pend_a[7:0], b1: 8'd0, b2: 8'd0, nbytes: 2'd1, is_end: 1'b1};
        end else if (cnt_a == 2'd2) begin
          grp_b_vld = 1'b1;
          grp_b = '{b0: pend_a[15:8], b1: pend_a[7:0], b2: 8'd0, nbytes: 2'd2,
                    is_end: 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

  // Pick the one group this request releases, or an empty end marker
  always_comb begin
    produce = grp_a_vld || grp_b_vld || (in_data.command == CMD_END);
    if (grp_b_vld) begin
      job_nxt = grp_b;
    end else if (grp_a_vld) begin
      job_nxt = grp_a;
    end else begin
      job_nxt = '{b0: 8'd0, b1: 8'd0, b2: 8'd0, nbytes: GRP_EMPTY, is_end: 1'b0};
    end
    job_nxt.is_end = (in_data.command == CMD_END);
  end

  // Hold gather state and the job register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      cnt_r       <= '0;
      colon_r     <= 1'b0;
      job_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        pend_r      <= pend_nxt;
        cnt_r       <= cnt_nxt;
        colon_r     <= colon_nxt;
        job_valid_r <= produce;
      end else if (job_pop) begin
        job_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r <= job_nxt;
    end
  end

  assign job_valid = job_valid_r;
  assign job       = job_r;

  // A single request never completes two groups
  a_one_group: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !(grp_a_vld && grp_b_vld))
    else $error("two groups released by one request");

  // The gather count never exceeds two bytes
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("pending count out of range");

endmodule

FILE: hdl/cbe_emit.sv
// Character emitter: streams four characters per group or an end marker
// into the result register and tracks output position. Depends on cbe_pkg.
`timescale 1ns / 1ps

module cbe_emit import cbe_pkg::*; #(
  parameter int LIMIT_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_valid,
  input  cbe_job_t              job,
  output logic                  job_pop,
  input  logic [LIMIT_BITS-1:0] limit,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cbe_out_t              out_data
);

  localparam int CmpW = (LIMIT_BITS > LEN_BITS ? LIMIT_BITS : LEN_BITS) + 1;

  logic [1:0]          idx_r;
  logic [LEN_BITS-1:0] pos_r, pos_nxt, pos_inc;
  logic                out_valid_r;
  cbe_out_t            out_r, res;
  logic                slot_free, fire, last_char, marker;
  logic [CmpW-1:0]     pos_ext, lim_ext;

  assign slot_free = !out_valid_r || out_ready;
  assign fire      = job_valid && slot_free;
  assign marker    = (job.nbytes == GRP_EMPTY);
  assign last_char = marker || (idx_r == 2'd3);
  assign job_pop   = fire && last_char;

  assign pos_inc = (pos_r == LEN_MAX) ? pos_r : pos_r + 1'b1;
  assign pos_ext = CmpW'(pos_r) + 1'b1;
  assign lim_ext = CmpW'(limit);

  // Select the character for the current slot of the group
  always_comb begin
    res = '0;
    unique case (idx_r)
      2'd0: res.out_char = cbe_sym(job.b0[7:2]);
      2'd1: res.out_char = cbe_sym({job.b0[1:0], job.b1[7:4]});
      2'd2: res.out_char = (job.nbytes < 2'd2) ? CHAR_PAD
                                               : cbe_sym({job.b1[3:0], job.b2[7:6]});
      2'd3: res.out_char = (job.nbytes < 2'd3) ? CHAR_PAD : cbe_sym(job.b2[5:0]);
      default: res.out_char = CHAR_PAD;
    endcase
    res.char_present = 1'b1;
    res.char_kept    = (pos_ext < lim_ext);
    pos_nxt          = pos_inc;
    if (marker) begin
      res     = '0;
      pos_nxt = pos_r;
    end
    res.last_result = job.is_end && last_char;
    if (res.last_result) begin
      res.required_length = pos_nxt;
      pos_nxt             = '0;
    end
  end

  // Advance through the group and hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        idx_r       <= last_char ? 2'd0 : idx_r + 2'd1;
        pos_r       <= pos_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Position returns to zero after the last result of a credential
  a_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.last_result) |=> (pos_r == '0))
    else $error("position not cleared after end");

  // An empty marker is only ever emitted as the end result
  a_marker_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.char_present) |-> (out_r.last_result && !out_r.char_kept))
    else $error("empty marker without end flag");

endmodule
